@@ hw/rtl/rdq_pkg.sv @@
// Shared types and codes for the reversible deque.
// Transaction structs, operation and status codes, control state type.
// No dependencies.
package rdq_pkg;

  typedef logic [2:0] op_t;
  localparam op_t OP_PUSH_FRONT = 3'd0;
  localparam op_t OP_POP_FRONT  = 3'd1;
  localparam op_t OP_PUSH_BACK  = 3'd2;
  localparam op_t OP_POP_BACK   = 3'd3;
  localparam op_t OP_REVERSE    = 3'd4;
  localparam op_t OP_LIST       = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_EMPTY = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] item;
    status_t            status;
    logic               final_res;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

endpackage

@@ hw/rtl/reversible_deque.sv @@
// Bounded double-ended queue of signed 32-bit values kept in a ring memory.
// Push, pop and reverse each give one status transaction; a list of N stored entries
// gives N results, one read a cycle through the single registered read port of the
// entry memory when the output is not stalled. Reverse only flips a direction flag;
// no data moves. The entry memory needs no clearing pass after reset.
// Depends on rdq_pkg.
module reversible_deque #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rdq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rdq_pkg::out_t out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // Ring memory: one write port, one registered read port
  logic [31:0]      mem [DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [31:0]      mem_wdata;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      rd_data_r;

  rdq_pkg::state_t  state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rev_r, rev_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_last_r, pend_last_nxt;
  logic             out_valid_r, out_valid_nxt;
  rdq_pkg::out_t    out_data_r, out_data_nxt;

  logic             out_free;
  logic             in_acc;
  logic             move;
  logic             is_empty;
  logic             is_full;
  logic             list_start;
  logic [CNT_W-1:0] rd_off;

  function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] base,
                                               logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign is_empty   = (cnt_r == '0);
  assign is_full    = (cnt_r == CNT_W'(DEPTH));
  assign out_free   = !out_valid_r || !out_stall;
  assign in_acc     = in_valid && !in_stall;
  assign list_start = in_acc && (in_data.operation == rdq_pkg::OP_LIST) && !is_empty;
  assign rd_off     = rev_r ? (cnt_r - 1'b1 - idx_r) : idx_r;
  assign rd_addr    = slot_of(front_r, rd_off);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rdq_pkg::ST_IDLE: begin
        if (list_start) begin
          state_nxt = rdq_pkg::ST_LIST;
        end
      end
      rdq_pkg::ST_LIST: begin
        if (move && pend_last_r) begin
          state_nxt = rdq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rdq_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall = 1'b1;
    move     = 1'b0;
    rd_en    = 1'b0;
    unique case (state_r)
      rdq_pkg::ST_IDLE: begin
        in_stall = !out_free;
      end
      rdq_pkg::ST_LIST: begin
        move  = pend_r && out_free;
        // issue a read only when the read register is free or being drained
        rd_en = (idx_r != cnt_r) && (!pend_r || move);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Datapath
  always_comb begin
    front_nxt     = front_r;
    cnt_nxt       = cnt_r;
    rev_nxt       = rev_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = front_r;
    mem_wdata     = in_data.value;

    if (in_acc) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.item      = '0;
      out_data_nxt.status    = rdq_pkg::STAT_OK;
      out_data_nxt.final_res = 1'b1;
      unique case (in_data.operation)
        rdq_pkg::OP_PUSH_FRONT, rdq_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            out_data_nxt.status = rdq_pkg::STAT_FULL;
          end else begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            if ((in_data.operation == rdq_pkg::OP_PUSH_FRONT) == !rev_r) begin
              front_nxt = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
              mem_waddr = front_nxt;
            end else begin
              mem_waddr = slot_of(front_r, cnt_r);
            end
          end
        end
        rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_POP_BACK: begin
          if (is_empty) begin
            out_data_nxt.status = rdq_pkg::STAT_EMPTY;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
            if ((in_data.operation == rdq_pkg::OP_POP_FRONT) == !rev_r) begin
              front_nxt = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;
            end
          end
        end
        rdq_pkg::OP_REVERSE: begin
          if (is_empty) begin
            out_data_nxt.status = rdq_pkg::STAT_EMPTY;
          end else begin
            rev_nxt = !rev_r;
          end
        end
        rdq_pkg::OP_LIST: begin
          if (is_empty) begin
            out_data_nxt.status = rdq_pkg::STAT_EMPTY;
          end else begin
            // results come from the read path
            out_valid_nxt = out_free ? 1'b0 : out_valid_r;
            out_data_nxt  = out_data_r;
            idx_nxt       = '0;
            pend_nxt      = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (move) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.item      = rd_data_r;
      out_data_nxt.status    = rdq_pkg::STAT_OK;
      out_data_nxt.final_res = pend_last_r;
      pend_nxt               = 1'b0;
    end

    if (rd_en) begin
      idx_nxt       = idx_r + 1'b1;
      pend_nxt      = 1'b1;
      pend_last_nxt = (idx_r == cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdq_pkg::ST_IDLE;
      front_r     <= '0;
      cnt_r       <= '0;
      rev_r       <= 1'b0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      cnt_r       <= cnt_nxt;
      rev_r       <= rev_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/rdq_checker.sv @@
// Port-level checks for the reversible deque, bound to its top level.
// Depends on rdq_pkg and reversible_deque.
module rdq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input rdq_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input rdq_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= rdq_pkg::STAT_FULL)
    else $error("undefined status code");

  a_midlist_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.final_res |-> out_data.status == rdq_pkg::STAT_OK)
    else $error("non-final result without ok status");

  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != rdq_pkg::STAT_OK
      |-> out_data.final_res && out_data.item == 32'sd0)
    else $error("failing result not single or item not zero");

  a_status_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.operation != rdq_pkg::OP_LIST
      |=> out_valid && out_data.final_res)
    else $error("status result missing after transaction");

endmodule

bind reversible_deque rdq_checker u_rdq_checker (.*);
